// File: hdl/sipq_pkg.sv
// Shared types and constants for the sorted-insert priority queue.
// No dependencies; used by sipq_cell and sorted_insert_priority_queue_unit.
package sipq_pkg;

  localparam int TAG_W  = 16;
  localparam int KEY_W  = 32;
  localparam int PRIO_W = 8;
  localparam int ORD_W  = 16;
  localparam int CNT_OUT_W = 5;

  // order_mode register values
  localparam logic [1:0] MODE_PRIO    = 2'd0;
  localparam logic [1:0] MODE_ARRIVAL = 2'd1;
  localparam logic [1:0] MODE_ORDNUM  = 2'd2;
  localparam logic [1:0] MODE_FIFO    = 2'd3;

  // op codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // result status codes
  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_REMOVED  = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [KEY_W-1:0] key;
  } entry_t;

  // Broadcast from the top level to every cell.
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [1:0]       mode;
    logic [TAG_W-1:0] new_tag;
    logic [KEY_W-1:0] new_key;
  } cell_ctrl_t;

endpackage

// File: hdl/sipq_cell.sv
// One slot of the ordered store: holds a tag and key, shifts with neighbors.
// Depends on sipq_pkg.
module sipq_cell #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic                clk,
  input  sipq_pkg::cell_ctrl_t ctrl,
  input  logic [CW-1:0]       count,
  input  logic                found_in,
  output logic                found_out,
  input  sipq_pkg::entry_t    left,
  input  sipq_pkg::entry_t    right,
  output sipq_pkg::entry_t    slot
);

  logic occupied;
  logic at_tail;
  logic hit;

  assign occupied = CW'(IDX) < count;
  assign at_tail  = count == CW'(IDX);

  // New entry belongs in front of this slot's entry.
  always_comb begin
    case (ctrl.mode)
      sipq_pkg::MODE_PRIO:    hit = occupied && (slot.key < ctrl.new_key);
      sipq_pkg::MODE_ARRIVAL,
      sipq_pkg::MODE_ORDNUM:  hit = occupied && (slot.key >= ctrl.new_key);
      default:                hit = 1'b0;
    endcase
  end

  assign found_out = found_in | hit;

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (found_in) begin
        slot <= left;
      end else if (hit || at_tail) begin
        slot <= '{tag: ctrl.new_tag, key: ctrl.new_key};
      end
    end else if (ctrl.rem) begin
      slot <= right;
    end
  end

endmodule

// File: hdl/sorted_insert_priority_queue_unit.sv
// Top level of the sorted-insert priority queue: stream ports, count,
// result register and the row of sipq_cell slots. Depends on sipq_pkg.
//
// The queue keeps up to DEPTH entries in a row of cells, the head in cell 0.
// It takes one insert or remove per clock as long as results are taken, and
// presents the result in the cycle after the item is accepted. A new item
// enters in the same cycle that the previous result is taken; while a result
// waits untaken, the input is held off. The cycle is set by one key compare
// in every cell plus the placement flag rippling down the row of cells.
// Change order_mode only while the queue is idle; held entries are not
// re-sorted.
module sorted_insert_priority_queue_unit #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: order_mode
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,  // tag[15:0], priority_req[23:16],
                                // arrival_time[55:24], order_number[71:56]
  input  logic        s_tuser,  // op
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,  // out_tag[15:0], entry_count[20:16],
                                // is_empty[21], zero[23:22]
  output logic [1:0]  m_tuser   // status
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [1:0]    order_mode;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  logic          in_acc;
  logic          is_full;
  logic          is_zero;
  logic          ins_go;
  logic          rem_go;
  logic [1:0]    status_next;

  logic [sipq_pkg::TAG_W-1:0]  in_tag;
  logic [sipq_pkg::PRIO_W-1:0] in_prio;
  logic [sipq_pkg::KEY_W-1:0]  in_arrival;
  logic [sipq_pkg::ORD_W-1:0]  in_ordnum;

  sipq_pkg::cell_ctrl_t ctrl;
  sipq_pkg::entry_t     slots [DEPTH];
  logic [DEPTH-1:0]     found;

  // result register
  logic [1:0]                   res_status;
  logic [sipq_pkg::TAG_W-1:0]   res_tag;
  logic [sipq_pkg::CNT_OUT_W-1:0] res_count;
  logic                         res_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      order_mode <= sipq_pkg::MODE_FIFO;
    end else if (cfg_valid && cfg_ready) begin
      order_mode <= cfg_data;
    end
  end

  assign in_tag     = s_tdata[15:0];
  assign in_prio    = s_tdata[23:16];
  assign in_arrival = s_tdata[55:24];
  assign in_ordnum  = s_tdata[71:56];

  assign s_tready = !m_tvalid || m_tready;
  assign in_acc   = s_tvalid && s_tready;
  assign is_full  = count == CW'(DEPTH);
  assign is_zero  = count == '0;
  assign ins_go   = in_acc && (s_tuser == sipq_pkg::OP_INSERT) && !is_full;
  assign rem_go   = in_acc && (s_tuser == sipq_pkg::OP_REMOVE) && !is_zero;

  always_comb begin
    ctrl.ins     = ins_go;
    ctrl.rem     = rem_go;
    ctrl.mode    = order_mode;
    ctrl.new_tag = in_tag;
    case (order_mode)
      sipq_pkg::MODE_PRIO:    ctrl.new_key = sipq_pkg::KEY_W'(in_prio);
      sipq_pkg::MODE_ARRIVAL: ctrl.new_key = in_arrival;
      sipq_pkg::MODE_ORDNUM:  ctrl.new_key = sipq_pkg::KEY_W'(in_ordnum);
      default:                ctrl.new_key = '0;
    endcase
  end

  always_comb begin
    count_next = count;
    if (ins_go) begin
      count_next = count + CW'(1);
    end else if (rem_go) begin
      count_next = count - CW'(1);
    end
    if (s_tuser == sipq_pkg::OP_INSERT) begin
      status_next = is_full ? sipq_pkg::ST_FULL : sipq_pkg::ST_INSERTED;
    end else begin
      status_next = is_zero ? sipq_pkg::ST_EMPTY : sipq_pkg::ST_REMOVED;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sipq_pkg::entry_t left_e;
    sipq_pkg::entry_t right_e;
    logic             f_in;

    if (i == 0) begin : g_head
      assign left_e = slots[0];
      assign f_in   = 1'b0;
    end else begin : g_body
      assign left_e = slots[i-1];
      assign f_in   = found[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_e = slots[i];
    end else begin : g_inner
      assign right_e = slots[i+1];
    end

    sipq_cell #(
      .IDX(i),
      .CW (CW)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .count    (count),
      .found_in (f_in),
      .found_out(found[i]),
      .left     (left_e),
      .right    (right_e),
      .slot     (slots[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (in_acc) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_status <= status_next;
      res_tag    <= rem_go ? slots[0].tag : '0;
      res_count  <= sipq_pkg::CNT_OUT_W'(count_next);
      res_empty  <= count_next == '0;
    end
  end

  assign m_tdata = {2'b00, res_empty, res_count, res_tag};
  assign m_tuser = res_status;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above DEPTH");

  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    (in_acc && (s_tuser == sipq_pkg::OP_INSERT) && is_full)
      |=> (count == $past(count)) && (m_tuser == sipq_pkg::ST_FULL))
    else $error("dropped insert changed the store");

  a_remove: assert property (@(posedge clk) disable iff (rst)
    (in_acc && (s_tuser == sipq_pkg::OP_REMOVE) && !is_zero)
      |=> (m_tuser == sipq_pkg::ST_REMOVED) && (count == $past(count) - CW'(1)))
    else $error("remove did not take one entry");

endmodule

// File: tb/sv/tb_sorted_insert_priority_queue_unit.sv
// Self-checking bench for sorted_insert_priority_queue_unit: random and directed
// inserts/removes across all order modes, checked against an in-bench queue model.
// Depends on sipq_pkg and the RTL of the queue unit.

// Keeps its own copy of the ordered store and the awaited results.
class sipq_scoreboard #(int DEPTH = 16);

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] tag;
    logic [4:0]  count;
    logic        empty;
  } outcome_t;

  outcome_t    awaited[$];
  logic [1:0]  mode;
  logic [15:0] slot_tags[DEPTH];
  logic [31:0] slot_keys[DEPTH];
  int          held;
  int          errors;

  function new();
    mode   = sipq_pkg::MODE_FIFO;
    held   = 0;
    errors = 0;
  endfunction

  function void set_mode(logic [1:0] m);
    mode = m;
  endfunction

  function int pending();
    return awaited.size();
  endfunction

  // Apply one accepted access to the store and queue up its result.
  function void note_access(logic op, logic [15:0] tag, logic [7:0] prio,
                            logic [31:0] arrival, logic [15:0] ordnum);
    outcome_t    o;
    logic [31:0] key;
    int          pos;
    bit          found;
    o.tag = '0;
    if (op == sipq_pkg::OP_INSERT) begin
      if (held >= DEPTH) begin
        o.status = sipq_pkg::ST_FULL;
      end else begin
        case (mode)
          sipq_pkg::MODE_PRIO:    key = {24'd0, prio};
          sipq_pkg::MODE_ARRIVAL: key = arrival;
          sipq_pkg::MODE_ORDNUM:  key = {16'd0, ordnum};
          default:                key = '0;
        endcase
        pos   = held;
        found = 0;
        // Scan from the head; held keys keep whatever order they came in with.
        if (mode != sipq_pkg::MODE_FIFO) begin
          for (int i = 0; i < held; i++) begin
            if (!found) begin
              if (mode == sipq_pkg::MODE_PRIO ? (slot_keys[i] < key)
                                              : (slot_keys[i] >= key)) begin
                pos   = i;
                found = 1;
              end
            end
          end
        end
        for (int i = held; i > pos; i--) begin
          slot_tags[i] = slot_tags[i-1];
          slot_keys[i] = slot_keys[i-1];
        end
        slot_tags[pos] = tag;
        slot_keys[pos] = key;
        held++;
        o.status = sipq_pkg::ST_INSERTED;
      end
    end else begin
      if (held == 0) begin
        o.status = sipq_pkg::ST_EMPTY;
      end else begin
        o.tag = slot_tags[0];
        for (int i = 1; i < held; i++) begin
          slot_tags[i-1] = slot_tags[i];
          slot_keys[i-1] = slot_keys[i];
        end
        held--;
        o.status = sipq_pkg::ST_REMOVED;
      end
    end
    o.count = held[4:0];
    o.empty = (held == 0);
    awaited.push_back(o);
  endfunction

  task report_mismatch(string what, int got, int want);
    if (errors < 30)
      $display("MISMATCH %s: got 0x%0h, want 0x%0h", what, got, want);
    errors++;
  endtask

  task check_result(logic [1:0] status, logic [23:0] data);
    outcome_t e;
    if (awaited.size() == 0) begin
      report_mismatch("result with nothing awaited", status, 0);
      return;
    end
    e = awaited.pop_front();
    if (status !== e.status)      report_mismatch("status", status, e.status);
    if (data[15:0] !== e.tag)     report_mismatch("out_tag", data[15:0], e.tag);
    if (data[20:16] !== e.count)  report_mismatch("entry_count", data[20:16], e.count);
    if (data[21] !== e.empty)     report_mismatch("is_empty", data[21], e.empty);
  endtask

endclass

module tb_sorted_insert_priority_queue_unit;

  localparam int QDEPTH       = 16;
  localparam int QUIET_LIMIT  = 5000;
  localparam int STALL_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;  // tag[15:0], priority_req[23:16],
                              // arrival_time[55:24], order_number[71:56]
  logic        s_tuser = 1'b0;  // op
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;       // out_tag[15:0], entry_count[20:16], is_empty[21]
  logic [1:0]  m_tuser;       // status

  sipq_scoreboard #(QDEPTH) sb;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit pressure_go = 0;
  bit pressure_done = 0;
  int stall_left = 0;
  int quiet = 0;
  bit filling = 1;

  sorted_insert_priority_queue_unit #(.DEPTH(QDEPTH)) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  always @(posedge clk) begin
    if (pressure_go && !pressure_done) begin
      pressure_done <= 1'b1;
      stall_left    <= STALL_CYCLES;
      m_tready      <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tuser, m_tdata);
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("tb_sorted_insert_priority_queue_unit: FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task send_item(logic op, logic [15:0] tag, logic [7:0] prio,
                 logic [31:0] arrival, logic [15:0] ordnum);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {ordnum, arrival, prio, tag};
    do @(posedge clk); while (!s_tready);
    sb.note_access(op, tag, prio, arrival, ordnum);
  endtask

  // Write order_mode once every awaited result is out.
  task set_mode(logic [1:0] m);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    sb.set_mode(m);
    cfg_valid <= 1'b0;
  endtask

  task run_random(int n);
    logic        op;
    bit          narrow;
    logic [7:0]  prio;
    logic [31:0] arrival;
    logic [15:0] ordnum;
    for (int k = 0; k < n; k++) begin
      // Swing between filling and draining so full and empty both come up.
      if (sb.held >= QDEPTH) filling = 0;
      if (sb.held == 0)      filling = 1;
      op = ($urandom_range(99) < (filling ? 75 : 25)) ? sipq_pkg::OP_INSERT
                                                      : sipq_pkg::OP_REMOVE;
      // Narrow keys make ties common.
      narrow  = ($urandom_range(1) == 0);
      prio    = narrow ? 8'($urandom_range(3)) : 8'($urandom_range(255));
      arrival = narrow ? 32'($urandom_range(3)) : $urandom();
      ordnum  = narrow ? 16'($urandom_range(3)) : 16'($urandom_range(65535));
      send_item(op, 16'($urandom_range(65535)), prio, arrival, ordnum);
    end
  endtask

  initial begin
    sb = new();
    rst <= 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    tx_idle_pct = 21;
    rx_idle_pct = 76;

    // FIFO after reset: empty remove, extreme tags, drain back to empty.
    send_item(sipq_pkg::OP_REMOVE, 16'h0000, 8'h00, 32'h0, 16'h0);
    send_item(sipq_pkg::OP_INSERT, 16'h0000, 8'h00, 32'h0, 16'h0);
    send_item(sipq_pkg::OP_INSERT, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(sipq_pkg::OP_REMOVE, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(sipq_pkg::OP_REMOVE, 16'h0000, 8'h00, 32'h0, 16'h0);
    send_item(sipq_pkg::OP_REMOVE, 16'h0000, 8'h00, 32'h0, 16'h0);

    // Priority order with a tie: the later equal key goes behind.
    set_mode(sipq_pkg::MODE_PRIO);
    send_item(sipq_pkg::OP_INSERT, 16'h0001, 8'h80, 32'h0, 16'h0);
    send_item(sipq_pkg::OP_INSERT, 16'h0002, 8'hFF, 32'h0, 16'h0);
    send_item(sipq_pkg::OP_INSERT, 16'h0003, 8'h80, 32'h0, 16'h0);
    send_item(sipq_pkg::OP_INSERT, 16'h0004, 8'h00, 32'h0, 16'h0);

    // Switch ordering with entries held; they stay where they are.
    set_mode(sipq_pkg::MODE_ARRIVAL);
    send_item(sipq_pkg::OP_INSERT, 16'h0005, 8'h00, 32'hFFFF_FFFF, 16'h0);
    send_item(sipq_pkg::OP_INSERT, 16'h0006, 8'h00, 32'h0000_0000, 16'h0);
    set_mode(sipq_pkg::MODE_ORDNUM);
    send_item(sipq_pkg::OP_INSERT, 16'h0007, 8'h00, 32'h0, 16'hFFFF);
    send_item(sipq_pkg::OP_INSERT, 16'h0008, 8'h00, 32'h0, 16'h0000);

    // Fill to the brim in FIFO order, then one insert too many.
    set_mode(sipq_pkg::MODE_FIFO);
    for (int k = 0; k < 9; k++)
      send_item(sipq_pkg::OP_INSERT, 16'(16'hA000 + k), 8'h00, 32'h0, 16'h0);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 21;
          rx_idle_pct = 76;
        end
        1: begin
          tx_idle_pct = 76;
          rx_idle_pct = 21;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 6; seg++) begin
        set_mode(2'((seg + ph) % 4));
        // Hold the receiver off while items keep coming, so the input stalls.
        if (ph == 2 && seg == 0) pressure_go = 1;
        run_random(100);
      end
    end

    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (sb.errors == 0)
      $display("tb_sorted_insert_priority_queue_unit: PASS");
    else
      $display("tb_sorted_insert_priority_queue_unit: FAIL");
    $finish;
  end

endmodule
